// ===== rtl/dpd_pkg.sv =====
// Shared types and constants for the DPD pair force pipeline.
`default_nettype none

package dpd_pkg;

  localparam int PADDR_W = 4;
  localparam int R2_W    = 62;
  localparam int ROOT_W  = R2_W / 2;
  localparam int W_SH    = 32;
  localparam int U_SH    = 30;
  localparam int SQ_LAT  = ROOT_W;
  localparam int W_LAT   = W_SH + 1;
  localparam int U_LAT   = U_SH + 1;
  localparam int U_PAD   = W_LAT - U_LAT;

  localparam logic [31:0] STRENGTH_RST = 32'd83886;
  localparam logic [30:0] CUTOFF_RST   = 31'd688128;
  localparam logic [31:0] DRAG_RST     = 32'd83886;
  localparam logic [1:0]  ENABLE_RST   = 2'd3;

  typedef enum logic [1:0] {
    REG_STRENGTH = 2'd0,
    REG_CUTOFF   = 2'd1,
    REG_DRAG     = 2'd2,
    REG_ENABLE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BEYOND     = 2'd1,
    ST_COINCIDENT = 2'd2,
    ST_SATURATED  = 2'd3
  } pair_status_t;

  typedef struct packed {
    logic signed [31:0] pos_i_x;
    logic signed [31:0] pos_i_y;
    logic signed [31:0] pos_i_z;
    logic signed [31:0] pos_j_x;
    logic signed [31:0] pos_j_y;
    logic signed [31:0] pos_j_z;
    logic signed [31:0] vel_i_x;
    logic signed [31:0] vel_i_y;
    logic signed [31:0] vel_i_z;
    logic signed [31:0] vel_j_x;
    logic signed [31:0] vel_j_y;
    logic signed [31:0] vel_j_z;
  } pair_in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [1:0]         pair_status;
  } pair_out_t;

  // Per-pair data that rides alongside the root and divider pipelines.
  typedef struct packed {
    logic [2:0][30:0] dm;
    logic [2:0]       dneg;
    logic [2:0][31:0] dvm;
    logic [2:0]       dvneg;
    logic             beyond;
    logic             coin;
  } side_t;

  typedef struct packed {
    logic [2:0][30:0] u;
    logic [2:0]       dneg;
    logic [2:0]       dvneg;
    logic             beyond;
    logic             coin;
  } tail_t;

endpackage

`default_nettype wire

// ===== rtl/dpd_pair_force.sv =====
// Top level of the DPD pair force pipeline with its register port.
`default_nettype none

// Channel  | Signals                         | Beat
// ---------+---------------------------------+-------------------------------
// req      | req_valid, req_ready, req       | one particle pair
// rsp      | rsp_valid, rsp_ready, rsp       | force on the first particle
// config   | psel penable pwrite paddr ...   | one 32-bit register write
//
// One pair enters per cycle while the pipeline is not stalled. The depth is
// set by the 31-stage square root and the 33-stage divider that forms the
// cutoff weight; the three unit-vector dividers run beside it.
// Reset clears the valid bits and loads the register defaults.
// The whole pipeline moves when the output register is empty or being taken;
// a stall freezes every stage, so nothing is lost or repeated.

module dpd_pair_force #(
  parameter int FORCE_FRAC_BITS = 28
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  output logic                        req_ready,
  input  wire dpd_pkg::pair_in_t      req,
  output logic                        rsp_valid,
  input  wire logic                   rsp_ready,
  output dpd_pkg::pair_out_t          rsp,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [dpd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready
);

  import dpd_pkg::*;

  localparam int SH    = 54 - FORCE_FRAC_BITS;
  localparam int SD_N  = SQ_LAT + 1 + W_LAT + 1;
  localparam int TL_N  = 9;

  // Register file.
  logic [31:0] strength;
  logic [30:0] cutoff;
  logic [31:0] drag;
  logic [1:0]  ten;
  logic [61:0] rc_sq;
  reg_idx_t    widx;
  reg_idx_t    ridx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= STRENGTH_RST;
      cutoff   <= CUTOFF_RST;
      drag     <= DRAG_RST;
      ten      <= ENABLE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_STRENGTH: strength <= pwdata;
        REG_CUTOFF:   cutoff   <= pwdata[30:0];
        REG_DRAG:     drag     <= pwdata;
        REG_ENABLE:   ten      <= pwdata[1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_STRENGTH: prdata = strength;
      REG_CUTOFF:   prdata = {1'b0, cutoff};
      REG_DRAG:     prdata = drag;
      REG_ENABLE:   prdata = {30'b0, ten};
      default:      prdata = '0;
    endcase
  end

  // The squared cutoff follows the register in the next cycle, well before any
  // pair can reach the compare.
  always_ff @(posedge clk) begin
    rc_sq <= cutoff * cutoff;
  end

  // Global advance.
  logic en;
  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  // Stage 1: separations and velocity differences as sign and magnitude.
  logic signed [31:0] pi [3];
  logic signed [31:0] pj [3];
  logic signed [31:0] vi [3];
  logic signed [31:0] vj [3];
  logic signed [32:0] dd [3];
  logic signed [32:0] dv [3];
  logic [32:0] dabs [3];
  logic [32:0] vabs [3];

  assign pi = '{req.pos_i_x, req.pos_i_y, req.pos_i_z};
  assign pj = '{req.pos_j_x, req.pos_j_y, req.pos_j_z};
  assign vi = '{req.vel_i_x, req.vel_i_y, req.vel_i_z};
  assign vj = '{req.vel_j_x, req.vel_j_y, req.vel_j_z};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dd[k]   = {pj[k][31], pj[k]} - {pi[k][31], pi[k]};
      dv[k]   = {vi[k][31], vi[k]} - {vj[k][31], vj[k]};
      dabs[k] = dd[k][32] ? 33'(-dd[k]) : 33'(dd[k]);
      vabs[k] = dv[k][32] ? 33'(-dv[k]) : 33'(dv[k]);
    end
  end

  logic        v1, v2, v3;
  logic [32:0] dm1 [3];
  side_t       sd1, sd2, sd3;
  logic [61:0] sq2 [3];
  logic        far2, far3;
  logic [63:0] r2_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dm1[k]       <= dabs[k];
        sd1.dm[k]    <= dabs[k][30:0];
        sd1.dneg[k]  <= dd[k][32];
        sd1.dvm[k]   <= vabs[k][31:0];
        sd1.dvneg[k] <= dv[k][32];
      end
      sd1.beyond <= 1'b0;
      sd1.coin   <= 1'b0;

      // Stage 2: squares of the separations and the per-axis cutoff test.
      for (int k = 0; k < 3; k++) begin
        sq2[k] <= dm1[k][30:0] * dm1[k][30:0];
      end
      far2 <= (dm1[0] >= {2'b0, cutoff}) || (dm1[1] >= {2'b0, cutoff}) ||
              (dm1[2] >= {2'b0, cutoff});
      sd2  <= sd1;

      // Stage 3: squared distance.
      r2_3 <= 64'(sq2[0]) + 64'(sq2[1]) + 64'(sq2[2]);
      far3 <= far2;
      sd3  <= sd2;
    end
  end

  // Stage 4 opens a delay line that carries the pair's data past the square
  // root (entries 0 to SQ_LAT) and past the dividers (up to SD_N-1).
  logic        vq [SD_N];
  side_t       sd [SD_N];
  side_t       sd4;
  logic [R2_W-1:0] rad4;

  always_comb begin
    sd4        = sd3;
    sd4.beyond = far3 || (r2_3 >= {2'b0, rc_sq});
    sd4.coin   = r2_3 == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq[0] <= 1'b0;
    end else if (en) begin
      vq[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= sd4;
      rad4  <= r2_3[R2_W-1:0];
    end
  end

  for (genvar n = 1; n < SD_N; n++) begin : g_line
    always_ff @(posedge clk) begin
      if (rst) begin
        vq[n] <= 1'b0;
      end else if (en) begin
        vq[n] <= vq[n-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sd[n] <= sd[n-1];
      end
    end
  end

  logic [ROOT_W-1:0] root;

  dpd_isqrt #(.XW(R2_W)) u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad4),
    .root (root)
  );

  // Stage 5: numerator of the weight.
  logic [30:0] numw5;
  logic [30:0] root5;

  always_ff @(posedge clk) begin
    if (en) begin
      numw5 <= cutoff - root;
      root5 <= root;
    end
  end

  logic [W_SH:0] wq;
  logic [U_SH:0] uq [3];
  logic [U_SH:0] upad [3][U_PAD+1];

  dpd_div #(.DW(31), .SH(W_SH)) u_div_w (
    .clk (clk),
    .en  (en),
    .num (numw5),
    .den (cutoff),
    .quo (wq)
  );

  for (genvar k = 0; k < 3; k++) begin : g_udiv
    dpd_div #(.DW(31), .SH(U_SH)) u_div_u (
      .clk (clk),
      .en  (en),
      .num (sd[SQ_LAT+1].dm[k]),
      .den (root5),
      .quo (uq[k])
    );

    assign upad[k][0] = uq[k];
    for (genvar m = 1; m <= U_PAD; m++) begin : g_pad
      always_ff @(posedge clk) begin
        if (en) begin
          upad[k][m] <= upad[k][m-1];
        end
      end
    end
  end

  // Stages 7 to 15 work on the weight and the unit vector.
  logic        vt [TL_N];
  tail_t       tl [TL_N];
  side_t       s6;
  logic [31:0] w6;

  assign s6 = sd[SD_N-1];
  assign w6 = wq[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < TL_N; n++) begin
        vt[n] <= 1'b0;
      end
    end else if (en) begin
      vt[0] <= vq[SD_N-1];
      for (int n = 1; n < TL_N; n++) begin
        vt[n] <= vt[n-1];
      end
    end
  end

  logic [62:0] p7 [3];
  logic [63:0] awf7, wwf7;
  logic [63:0] pos8, neg8, gwf8;
  logic [31:0] aw8, aw9, aw10, aw11, aw12;
  logic signed [64:0] diff9;
  logic [31:0] gw1_9, gw1_10;
  logic        pneg10, pneg11, pneg12, pneg13, pneg14;
  logic [63:0] pm10;
  logic [63:0] pl11, ph11;
  logic [95:0] gsum;
  logic [49:0] gw12;
  logic [62:0] c13 [3];
  logic [55:0] gl13 [3];
  logic [55:0] gh13 [3];
  logic [39:0] cm14 [3];
  logic [57:0] gm14 [3];
  logic [80:0] gfull [3];
  logic signed [59:0] f15 [3];
  logic signed [59:0] ct [3];
  logic signed [59:0] gt [3];

  assign gsum = {ph11, 32'b0} + 96'(pl11);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gfull[k] = {gh13[k], 25'b0} + 81'(gl13[k]);
      ct[k]    = $signed({20'b0, cm14[k]});
      gt[k]    = $signed({2'b0, gm14[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 7: projection terms and weight products.
      for (int k = 0; k < 3; k++) begin
        tl[0].u[k] <= upad[k][U_PAD];
        p7[k]      <= upad[k][U_PAD] * s6.dvm[k];
      end
      tl[0].dneg   <= s6.dneg;
      tl[0].dvneg  <= s6.dvneg;
      tl[0].beyond <= s6.beyond;
      tl[0].coin   <= s6.coin;
      awf7 <= strength * w6;
      wwf7 <= w6 * w6;

      for (int n = 1; n < TL_N; n++) begin
        tl[n] <= tl[n-1];
      end

      // Stage 8: split the projection by sign.
      pos8 <= (tl[0].dneg[0] == tl[0].dvneg[0] ? 64'(p7[0]) : 64'd0) +
              (tl[0].dneg[1] == tl[0].dvneg[1] ? 64'(p7[1]) : 64'd0) +
              (tl[0].dneg[2] == tl[0].dvneg[2] ? 64'(p7[2]) : 64'd0);
      neg8 <= (tl[0].dneg[0] != tl[0].dvneg[0] ? 64'(p7[0]) : 64'd0) +
              (tl[0].dneg[1] != tl[0].dvneg[1] ? 64'(p7[1]) : 64'd0) +
              (tl[0].dneg[2] != tl[0].dvneg[2] ? 64'(p7[2]) : 64'd0);
      aw8  <= awf7[63:32];
      gwf8 <= drag * wwf7[63:32];

      // Stage 9: net projection.
      diff9 <= $signed({1'b0, pos8}) - $signed({1'b0, neg8});
      aw9   <= aw8;
      gw1_9 <= gwf8[63:32];

      // Stage 10: its sign and magnitude.
      pneg10 <= diff9[64];
      pm10   <= diff9[64] ? 64'(-diff9) : diff9[63:0];
      aw10   <= aw9;
      gw1_10 <= gw1_9;

      // Stage 11: drag scale times projection, in two halves.
      pl11   <= gw1_10 * pm10[31:0];
      ph11   <= gw1_10 * pm10[63:32];
      aw11   <= aw10;
      pneg11 <= pneg10;

      // Stage 12: combine the halves.
      gw12   <= gsum[95:46];
      aw12   <= aw11;
      pneg12 <= pneg11;

      // Stage 13: both terms times the unit vector.
      for (int k = 0; k < 3; k++) begin
        c13[k]  <= aw12 * tl[5].u[k];
        gl13[k] <= gw12[24:0] * tl[5].u[k];
        gh13[k] <= gw12[49:25] * tl[5].u[k];
      end
      pneg13 <= pneg12;

      // Stage 14: scale to the output fraction.
      for (int k = 0; k < 3; k++) begin
        cm14[k] <= 40'(c13[k] >> SH);
        gm14[k] <= 58'(gfull[k] >> SH);
      end
      pneg14 <= pneg13;

      // Stage 15: signed sum of the enabled terms. The drag pushes against
      // the approach, so its sign follows the projection and the axis.
      for (int k = 0; k < 3; k++) begin
        f15[k] <= (ten[0] ? (tl[7].dneg[k] ? -ct[k] : ct[k]) : 60'sd0) +
                  (ten[1] ? ((pneg14 == tl[7].dneg[k]) ? -gt[k] : gt[k]) : 60'sd0);
      end
    end
  end

  // Output register: clip to 32 bits and pick the status.
  logic [31:0] fsat [3];
  logic [2:0]  clip;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      clip[k] = !((&f15[k][59:31]) || !(|f15[k][59:31]));
      if (!clip[k]) begin
        fsat[k] = f15[k][31:0];
      end else if (f15[k][59]) begin
        fsat[k] = 32'h8000_0000;
      end else begin
        fsat[k] = 32'h7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= vt[TL_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (tl[8].beyond) begin
        rsp.force_x     <= '0;
        rsp.force_y     <= '0;
        rsp.force_z     <= '0;
        rsp.pair_status <= ST_BEYOND;
      end else if (tl[8].coin) begin
        rsp.force_x     <= '0;
        rsp.force_y     <= '0;
        rsp.force_z     <= '0;
        rsp.pair_status <= ST_COINCIDENT;
      end else begin
        rsp.force_x     <= fsat[0];
        rsp.force_y     <= fsat[1];
        rsp.force_z     <= fsat[2];
        rsp.pair_status <= (|clip) ? ST_SATURATED : ST_OK;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dpd_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module dpd_isqrt #(
  parameter int XW = 62
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [XW-1:0]     rad,
  output logic      [XW/2-1:0]   root
);

  localparam int H  = XW / 2;
  localparam int RW = H + 3;

  logic [XW-1:0] xs [H+1];
  logic [RW-1:0] rs [H+1];
  logic [H-1:0]  qs [H+1];

  assign xs[0] = rad;
  assign rs[0] = '0;
  assign qs[0] = '0;

  for (genvar i = 0; i < H; i++) begin : g_stage
    logic [RW-1:0] rsh;
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
      rsh   = {rs[i][RW-3:0], xs[i][XW-1 -: 2]};
      trial = RW'({qs[i], 2'b01});
      ge    = rsh >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[i+1] <= xs[i] << 2;
        rs[i+1] <= ge ? rsh - trial : rsh;
        qs[i+1] <= {qs[i][H-2:0], ge};
      end
    end
  end

  assign root = qs[H];

endmodule

`default_nettype wire

// ===== rtl/dpd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module dpd_div #(
  parameter int DW = 31,
  parameter int SH = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [SH:0]   quo
);

  // The user must keep the numerator at or below the divisor (not enforced here); the quotient then fits SH+1 bits.
  localparam int RW = DW + 1;
  localparam int N  = SH + 1;

  logic [RW-1:0] rem [N+1];
  logic [DW-1:0] dd  [N+1];
  logic [SH:0]   q   [N+1];

  assign rem[0] = RW'(num);
  assign dd[0]  = den;
  assign q[0]   = '0;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RW-1:0] rsh;
    logic          ge;

    if (i == 0) begin : g_first
      assign rsh = rem[i];
    end else begin : g_rest
      assign rsh = {rem[i][DW-1:0], 1'b0};
    end

    assign ge = rsh >= {1'b0, dd[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? rsh - {1'b0, dd[i]} : rsh;
        dd[i+1]  <= dd[i];
        q[i+1]   <= {q[i][SH-1:0], ge};
      end
    end
  end

  assign quo = q[N];

endmodule

`default_nettype wire

// ===== dv/dpd_force_checker.sv =====
// Checker that predicts and compares the DPD pair force results.
`timescale 1ns / 100ps

module dpd_force_checker
  import dpd_pkg::*;
#(
  parameter int FORCE_FRAC_BITS = 28
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_ready,
  input  pair_in_t            req,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  pair_out_t           rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output int                  mismatches,
  output int                  forces_pending
);

  localparam longint unsigned CAP = 64'd1 << 62;

  logic [31:0] strength;
  logic [30:0] cutoff;
  logic [31:0] drag;
  logic [1:0]  enables;

  pair_out_t expected_forces[$];

  assign forces_pending = expected_forces.size();

  // Product shifted right, clipped at the per-term cap.
  function automatic longint unsigned cap_mul(longint unsigned a, longint unsigned b,
                                              int unsigned sh);
    logic [127:0] prod;
    prod = ({64'd0, a} * {64'd0, b}) >> sh;
    return (prod > CAP) ? CAP : prod[63:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w >>= 2;
    while (bit_w != 0) begin
      if (x >= res + bit_w) begin
        x -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic pair_out_t pair_force(pair_in_t p);
    longint d[3], dv[3], f, c, g;
    longint unsigned dm[3], u[3], dvm, r2, rc, r, w, aw, gw, pos, neg, pm, prod;
    logic signed [31:0] pi[3], pj[3], vi[3], vj[3];
    bit pneg, beyond, sat, gneg;
    int unsigned sh;
    pair_out_t o;
    pi = '{p.pos_i_x, p.pos_i_y, p.pos_i_z};
    pj = '{p.pos_j_x, p.pos_j_y, p.pos_j_z};
    vi = '{p.vel_i_x, p.vel_i_y, p.vel_i_z};
    vj = '{p.vel_j_x, p.vel_j_y, p.vel_j_z};
    sh = 54 - FORCE_FRAC_BITS;
    rc = cutoff;
    r2 = 0;
    pos = 0;
    neg = 0;
    beyond = 0;
    sat = 0;
    o = '0;
    for (int k = 0; k < 3; k++) begin
      d[k]  = longint'(pj[k]) - longint'(pi[k]);
      dv[k] = longint'(vi[k]) - longint'(vj[k]);
      dm[k] = d[k] < 0 ? -d[k] : d[k];
      if (dm[k] >= rc) beyond = 1;
    end
    if (!beyond) begin
      for (int k = 0; k < 3; k++) r2 += dm[k] * dm[k];
      if (r2 >= rc * rc) beyond = 1;
    end
    if (beyond) begin
      o.pair_status = ST_BEYOND;
      return o;
    end
    if (r2 == 0) begin
      o.pair_status = ST_COINCIDENT;
      return o;
    end
    r = int_sqrt(r2);
    w = ((rc - r) << 32) / rc;
    for (int k = 0; k < 3; k++) begin
      u[k] = (dm[k] << 30) / r;
      dvm = dv[k] < 0 ? -dv[k] : dv[k];
      prod = u[k] * dvm;
      if ((d[k] < 0) != (dv[k] < 0)) neg += prod;
      else pos += prod;
    end
    pneg = neg > pos;
    pm = pneg ? neg - pos : pos - neg;
    aw = cap_mul(strength, w, 32);
    gw = cap_mul(drag, cap_mul(w, w, 32), 32);
    gw = cap_mul(gw, pm, 46);
    for (int k = 0; k < 3; k++) begin
      f = 0;
      if (enables[0]) begin
        c = cap_mul(aw, u[k], sh);
        f += d[k] < 0 ? -c : c;
      end
      if (enables[1]) begin
        g = cap_mul(gw, u[k], sh);
        gneg = !(pneg != (d[k] < 0));
        f += gneg ? -g : g;
      end
      if (f > 64'sh7FFF_FFFF) begin
        f = 64'sh7FFF_FFFF;
        sat = 1;
      end
      if (f < -64'sh8000_0000) begin
        f = -64'sh8000_0000;
        sat = 1;
      end
      case (k)
        0: o.force_x = f[31:0];
        1: o.force_y = f[31:0];
        default: o.force_z = f[31:0];
      endcase
    end
    o.pair_status = sat ? ST_SATURATED : ST_OK;
    return o;
  endfunction

  always @(posedge clk) begin
    pair_out_t want;
    if (rst) begin
      strength <= STRENGTH_RST;
      cutoff   <= CUTOFF_RST;
      drag     <= DRAG_RST;
      enables  <= ENABLE_RST;
      expected_forces.delete();
      mismatches <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_STRENGTH: strength <= pwdata;
          REG_CUTOFF:   cutoff   <= pwdata[30:0];
          REG_DRAG:     drag     <= pwdata;
          REG_ENABLE:   enables  <= pwdata[1:0];
        endcase
      end
      if (req_valid && req_ready) expected_forces.push_back(pair_force(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_forces.size() == 0) begin
          if (mismatches < 10) $display("unexpected force beat %h", rsp);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_forces.pop_front();
          if (want !== rsp) begin
            if (mismatches < 10)
              $display("force mismatch: expected x=%h y=%h z=%h st=%0d, got x=%h y=%h z=%h st=%0d",
                       want.force_x, want.force_y, want.force_z, want.pair_status,
                       rsp.force_x, rsp.force_y, rsp.force_z, rsp.pair_status);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: stimulus and verdict for the DPD pair force block.
`timescale 1ns / 100ps

module tb_top;
  import dpd_pkg::*;

  logic clk, rst;
  logic req_valid, req_ready, rsp_valid, rsp_ready;
  pair_in_t  req;
  pair_out_t rsp;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int mismatches, forces_pending;

  // When set, neither side inserts gaps, so back-to-back beats get exercised.
  bit no_idle;
  int unsigned reach;

  dpd_pair_force u_top (
    .clk, .rst, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dpd_force_checker u_checker (
    .clk, .rst, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatches, .forces_pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Timeout guard: the slowest legal run is far below this.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // Response side: a random stall ahead of each beat, then hold ready until it moves.
  initial begin
    int n;
    rsp_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 5);
      if (n != 0) begin
        rsp_ready <= 0;
        repeat (n) @(negedge clk);
      end
      rsp_ready <= 1;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  // Register write with a setup and an access phase; the block takes it at the access cycle.
  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel    <= 0;
    penable <= 0;
    @(negedge clk);
  endtask

  task automatic send_pair(pair_in_t p);
    int n;
    n = no_idle ? 0 : $urandom_range(0, 5);
    if (n != 0) begin
      req_valid <= 0;
      repeat (n) @(negedge clk);
    end
    req       <= p;
    req_valid <= 1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // Drop valid, drain all outstanding forces, then let the pipe go quiet.
  task automatic drain();
    req_valid <= 0;
    while (forces_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_vec(bit full, int unsigned lim);
    if (full) return $urandom;
    return $urandom_range(0, 2 * lim) - lim;
  endfunction

  // Mostly pairs inside the cutoff with random content; the rest is full-range noise.
  task automatic random_pairs(int count, int unsigned rc);
    pair_in_t p;
    int unsigned lim;
    bit noise, fast;
    lim = rc / 2;
    if (lim > (1 << 29)) lim = 1 << 29;
    for (int i = 0; i < count; i++) begin
      noise = $urandom_range(0, 9) == 0;
      fast  = $urandom_range(0, 3) == 0;
      p.pos_i_x = rand_vec(noise, 1 << 29);
      p.pos_i_y = rand_vec(noise, 1 << 29);
      p.pos_i_z = rand_vec(noise, 1 << 29);
      p.pos_j_x = noise ? $urandom : p.pos_i_x + rand_vec(0, lim);
      p.pos_j_y = noise ? $urandom : p.pos_i_y + rand_vec(0, lim);
      p.pos_j_z = noise ? $urandom : p.pos_i_z + rand_vec(0, lim);
      if ($urandom_range(0, 30) == 0) p.pos_j_x = p.pos_i_x;
      if ($urandom_range(0, 30) == 0) begin
        p.pos_j_y = p.pos_i_y;
        p.pos_j_z = p.pos_i_z;
      end
      p.vel_i_x = rand_vec(fast, 1 << 20);
      p.vel_i_y = rand_vec(fast, 1 << 20);
      p.vel_i_z = rand_vec(fast, 1 << 20);
      p.vel_j_x = rand_vec(fast, 1 << 20);
      p.vel_j_y = rand_vec(fast, 1 << 20);
      p.vel_j_z = rand_vec(fast, 1 << 20);
      send_pair(p);
    end
  endtask

  initial begin
    pair_in_t p;
    rst = 1;
    req_valid = 0;
    req = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    no_idle = 0;
    repeat (5) @(negedge clk);
    rst = 0;

    // Directed pairs at the default setting: the cutoff is 10.5 units.
    p = '0;
    send_pair(p);                               // coincident
    p.pos_j_x = 32'h0001_0000;
    send_pair(p);                               // one unit along x
    p.pos_j_x = 32'h000A_8000;
    send_pair(p);                               // exactly at the cutoff
    p.pos_j_x = 32'h000A_7FFF;
    send_pair(p);                               // just inside
    p = '0;
    p.pos_j_x = 32'h0006_0000;
    p.pos_j_y = 32'h0006_0000;
    p.pos_j_z = 32'h0006_0000;
    send_pair(p);                               // inside: the sum of squares stays below the cutoff squared
    p.pos_j_x = 32'hFFFC_0000;
    p.pos_j_y = 32'h0002_0000;
    p.pos_j_z = 32'hFFFF_0000;
    p.vel_i_x = 32'h7FFF_FFFF;
    p.vel_j_x = 32'h8000_0000;
    p.vel_i_y = 32'h8000_0000;
    p.vel_j_y = 32'h7FFF_FFFF;
    send_pair(p);                               // extreme velocities
    p = '0;
    p.pos_i_x = 32'h8000_0000;
    p.pos_j_x = 32'h7FFF_FFFF;
    send_pair(p);                               // extreme positions, far apart
    p.pos_i_x = 32'h7FFF_FFFF;
    p.pos_j_x = 32'h7FFF_FFFF;
    p.pos_i_y = 32'h8000_0000;
    p.pos_j_y = 32'h8000_0001;
    send_pair(p);                               // extremes, tiny separation
    drain();

    // Strong terms and the widest cutoff drive the sums into saturation.
    reg_write(REG_STRENGTH, 32'hFFFF_FFFF);
    reg_write(REG_CUTOFF, 32'h7FFF_FFFF);
    reg_write(REG_DRAG, 32'hFFFF_FFFF);
    reg_write(REG_ENABLE, 32'd3);
    p = '0;
    p.pos_j_x = 32'h4000_0000;
    p.vel_i_x = 32'h7FFF_FFFF;
    p.vel_j_x = 32'h8000_0000;
    send_pair(p);
    p.pos_j_y = 32'hC000_0000;
    send_pair(p);
    random_pairs(200, 32'h7FFF_FFFF);
    drain();

    // Neither term first, then each term on its own.
    for (int e = 0; e < 3; e++) begin
      reg_write(REG_CUTOFF, 32'h0020_0000 << (3 * e));
      reg_write(REG_ENABLE, 32'(e));
      reg_write(REG_STRENGTH, $urandom);
      reg_write(REG_DRAG, $urandom);
      no_idle = (e == 1);
      random_pairs(200, 32'h0020_0000 << (3 * e));
      drain();
    end
    no_idle = 0;

    // Smallest cutoff: only coincident or beyond.
    reg_write(REG_CUTOFF, 32'd1);
    reg_write(REG_ENABLE, 32'd3);
    reg_write(REG_STRENGTH, 32'd0);
    reg_write(REG_DRAG, 32'd0);
    random_pairs(100, 1);
    drain();

    // A few random settings to finish.
    for (int s = 0; s < 4; s++) begin
      reach = $urandom_range(1, 32'h7FFF_FFFF >> (2 * s));
      reg_write(REG_CUTOFF, reach);
      reg_write(REG_STRENGTH, $urandom);
      reg_write(REG_DRAG, $urandom >> (4 * s));
      reg_write(REG_ENABLE, 32'd3);
      no_idle = (s == 2);
      random_pairs(135, reach);
      drain();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
